[rtl/core/wsfmt_pkg.sv]
// Shared types and constants for the whitespace run formatter.
// Holds item structs, command, mode and status codes and default sizes.
// No dependencies.
`default_nettype none

package wsfmt_pkg;

  // Default sizes for the mode stack and the whitespace hold buffer.
  localparam int STACK_DEPTH_DEF = 16;
  localparam int HOLD_DEPTH_DEF  = 32;

  // Item kinds.
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_PUSH  = 2'd1;
  localparam logic [1:0] KIND_POP   = 2'd2;
  localparam logic [1:0] KIND_FLUSH = 2'd3;

  // Formatting modes.
  localparam logic [2:0] MODE_PASS         = 3'd0;
  localparam logic [2:0] MODE_NONE         = 3'd1;
  localparam logic [2:0] MODE_SINGLE_SPACE = 3'd2;
  localparam logic [2:0] MODE_SINGLE_NL    = 3'd3;
  localparam logic [2:0] MODE_FIRST_LINE   = 3'd4;
  localparam logic [2:0] MODE_SQUEEZE_NL   = 3'd5;
  localparam logic [2:0] MODE_COPYPREV     = 3'd6;
  localparam logic [2:0] MODE_UNDEFINED    = 3'd7;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_POP_LAST  = 2'd1;
  localparam logic [1:0] STAT_PUSH_FULL = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] in_char;
    logic [2:0] push_mode;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic [2:0] popped_mode;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SYNTH = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FINAL = 4'b1000
  } fsm_state_t;

endpackage

`default_nettype wire

[rtl/core/whitespace_run_formatter.sv]
// Whitespace run formatter top level. Uses wsfmt_pkg and wsfmt_ram.
// A byte or command with no held run reaches the output register in the
// cycle after its transfer; a new item can be taken every cycle while idle,
// with no pop loading the top mode and the output free. A held run is read
// back from the hold RAM at one byte a cycle while the output keeps up.
// Reset is synchronous (rst_n low): the stack returns to one entry holding
// mode 0 and the hold buffer is empty.
`default_nettype none

module whitespace_run_formatter #(
  parameter int STACK_DEPTH = wsfmt_pkg::STACK_DEPTH_DEF,
  parameter int HOLD_DEPTH  = wsfmt_pkg::HOLD_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input item channel.
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire wsfmt_pkg::in_item_t  in_data,
  // Result channel.
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output wsfmt_pkg::out_item_t      out_data,
  // Configuration: initial_mode register.
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_wdata
);

  // Widths derived from the two depths. Counters hold the depth itself,
  // addresses only what the RAM needs.
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int HCW = $clog2(HOLD_DEPTH + 1);
  localparam int HAW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  // Control state.
  wsfmt_pkg::fsm_state_t state_r, state_nxt;
  logic                  pending_r, pending_nxt;     // hold RAM read in flight
  logic                  top_load_r, top_load_nxt;   // stack RAM read in flight
  logic                  out_valid_r, out_valid_nxt;
  logic [SCW-1:0]        count_r, count_nxt;
  logic [HCW-1:0]        hold_count_r, hold_count_nxt;
  logic                  nl_r, nl_nxt;
  logic [2:0]            top_r, top_nxt;
  logic [2:0]            bottom_r, bottom_nxt;

  // Payload and drain plan.
  wsfmt_pkg::out_item_t  out_data_r, out_data_nxt;
  wsfmt_pkg::out_item_t  term_r, term_nxt;
  logic [HCW-1:0]        first_r, first_nxt;
  logic [HCW-1:0]        lastnl_r, lastnl_nxt;
  logic [HCW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [HCW-1:0]        a_end_r, a_end_nxt;
  logic [HCW-1:0]        b_start_r, b_start_nxt;
  logic [HCW-1:0]        end_r, end_nxt;
  logic                  b_en_r, b_en_nxt;
  logic                  seg_b_r, seg_b_nxt;
  logic [7:0]            synth_r, synth_nxt;

  // Memory ports.
  logic                  hram_we, hram_re;
  logic [HAW-1:0]        hram_waddr, hram_raddr;
  logic [7:0]            hram_wdata, hram_rdata;
  logic                  sram_we, sram_re;
  logic [SAW-1:0]        sram_waddr, sram_raddr;
  logic [2:0]            sram_wdata, sram_rdata;

  // Decode of the accepted item.
  logic                  acc, out_free, is_ws;
  logic                  do_end, do_hold, do_push, do_pop, term_en, run_drains;
  wsfmt_pkg::out_item_t  term;

  // Plan for rewriting the held run under the top mode.
  logic [HCW-1:0]        plan_a_end, plan_b_start, first_or_n;
  logic                  plan_b_en, plan_synth;
  logic [7:0]            plan_char;
  logic [SCW-1:0]        count_m2;

  // The hold buffer stores whitespace bytes of the current run; only entries
  // below the hold count are ever read back.
  wsfmt_ram #(
    .WIDTH (8),
    .DEPTH (HOLD_DEPTH)
  ) u_hold_ram (
    .clk   (clk),
    .we    (hram_we),
    .waddr (hram_waddr),
    .wdata (hram_wdata),
    .re    (hram_re),
    .raddr (hram_raddr),
    .rdata (hram_rdata)
  );

  // The mode stack keeps entries one and up in RAM. Entry zero is the
  // initial_mode register itself, so it is valid right out of reset.
  wsfmt_ram #(
    .WIDTH (3),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (sram_waddr),
    .wdata (sram_wdata),
    .re    (sram_re),
    .raddr (sram_raddr),
    .rdata (sram_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  // Items are taken only when idle, when the top mode is settled and when
  // the output register can take a result in the same cycle.
  assign in_ready  = (state_r == wsfmt_pkg::ST_IDLE) && !top_load_r && out_free;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_ws = (in_data.in_char == wsfmt_pkg::CH_SPACE) ||
                 ((in_data.in_char >= wsfmt_pkg::CH_TAB) &&
                  (in_data.in_char <= wsfmt_pkg::CH_CR));
  assign count_m2 = count_r - SCW'(2);

  // Work out what the accepted item does: whether it ends the held run,
  // holds a byte, moves the stack, and which closing result it gives.
  always_comb begin
    do_end  = 1'b0;
    do_hold = 1'b0;
    do_push = 1'b0;
    do_pop  = 1'b0;
    term_en = 1'b0;
    term    = '{out_char: wsfmt_pkg::CH_NUL, char_valid: 1'b0,
                popped_mode: wsfmt_pkg::MODE_PASS, status: wsfmt_pkg::STAT_OK,
                last: 1'b1};
    unique case (in_data.kind)
      wsfmt_pkg::KIND_CHAR: begin
        if ((top_r == wsfmt_pkg::MODE_PASS) || !is_ws) begin
          do_end          = 1'b1;
          term_en         = 1'b1;
          term.out_char   = in_data.in_char;
          term.char_valid = 1'b1;
        end else if (top_r != wsfmt_pkg::MODE_NONE) begin
          if (hold_count_r < HCW'(HOLD_DEPTH)) begin
            do_hold = 1'b1;
          end else begin
            // Buffer full: the byte is lost and the item reports it.
            term_en     = 1'b1;
            term.status = wsfmt_pkg::STAT_OVERFLOW;
          end
        end
      end
      wsfmt_pkg::KIND_PUSH: begin
        do_end  = 1'b1;
        term_en = 1'b1;
        if (count_r < SCW'(STACK_DEPTH)) begin
          do_push = 1'b1;
        end else begin
          term.status = wsfmt_pkg::STAT_PUSH_FULL;
        end
      end
      wsfmt_pkg::KIND_POP: begin
        term_en = 1'b1;
        if (count_r <= SCW'(1)) begin
          // Refused pop keeps the held run intact.
          term.popped_mode = wsfmt_pkg::MODE_UNDEFINED;
          term.status      = wsfmt_pkg::STAT_POP_LAST;
        end else begin
          do_end           = 1'b1;
          do_pop           = 1'b1;
          term.popped_mode = top_r;
        end
      end
      wsfmt_pkg::KIND_FLUSH: begin
        do_end  = 1'b1;
        term_en = 1'b1;
      end
      default: begin
        term_en = 1'b0;
      end
    endcase
    run_drains = do_end && (hold_count_r != '0);
  end

  // The held run is written back as at most two index ranges of the hold
  // buffer, or as one substituted character.
  always_comb begin
    first_or_n   = nl_r ? first_r : hold_count_r;
    plan_a_end   = hold_count_r;
    plan_b_start = hold_count_r;
    plan_b_en    = 1'b0;
    plan_synth   = 1'b0;
    plan_char    = wsfmt_pkg::CH_SPACE;
    unique case (top_r)
      wsfmt_pkg::MODE_NONE: begin
        plan_a_end = '0;
      end
      wsfmt_pkg::MODE_SINGLE_SPACE: begin
        plan_synth = 1'b1;
      end
      wsfmt_pkg::MODE_SINGLE_NL: begin
        if (nl_r) begin
          plan_synth = 1'b1;
          plan_char  = wsfmt_pkg::CH_NEWLINE;
        end
      end
      wsfmt_pkg::MODE_FIRST_LINE: begin
        plan_a_end = first_or_n;
      end
      wsfmt_pkg::MODE_SQUEEZE_NL: begin
        // With two or more newlines, keep through the first one and then
        // whatever follows the last one.
        if (nl_r && (first_r != lastnl_r)) begin
          plan_a_end   = first_r + HCW'(1);
          plan_b_start = lastnl_r + HCW'(1);
          plan_b_en    = 1'b1;
        end
      end
      default: begin
        plan_a_end = hold_count_r;
      end
    endcase
  end

  // Sequencer: accepts items, reads held bytes back one per cycle while the
  // output is free, and closes each item with its command or byte result.
  always_comb begin
    state_nxt      = state_r;
    pending_nxt    = pending_r;
    top_load_nxt   = top_load_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    count_nxt      = count_r;
    hold_count_nxt = hold_count_r;
    nl_nxt         = nl_r;
    top_nxt        = top_r;
    bottom_nxt     = bottom_r;
    term_nxt       = term_r;
    first_nxt      = first_r;
    lastnl_nxt     = lastnl_r;
    rd_idx_nxt     = rd_idx_r;
    a_end_nxt      = a_end_r;
    b_start_nxt    = b_start_r;
    end_nxt        = end_r;
    b_en_nxt       = b_en_r;
    seg_b_nxt      = seg_b_r;
    synth_nxt      = synth_r;

    hram_we    = 1'b0;
    hram_waddr = hold_count_r[HAW-1:0];
    hram_wdata = in_data.in_char;
    hram_re    = 1'b0;
    hram_raddr = rd_idx_r[HAW-1:0];
    sram_we    = 1'b0;
    sram_waddr = count_r[SAW-1:0];
    sram_wdata = in_data.push_mode;
    sram_re    = 1'b0;
    sram_raddr = count_m2[SAW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // The mode uncovered by a pop arrives from the stack RAM in the following cycle.
    if (top_load_r) begin
      top_nxt      = sram_rdata;
      top_load_nxt = 1'b0;
    end

    // Writing initial_mode also rewrites the bottom of the stack.
    if (cfg_we) begin
      bottom_nxt = cfg_wdata;
      if (count_r == SCW'(1)) begin
        top_nxt = cfg_wdata;
      end
    end

    // A held byte read earlier moves into the output register once free.
    if (pending_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{out_char: hram_rdata, char_valid: 1'b1,
                        popped_mode: wsfmt_pkg::MODE_PASS,
                        status: wsfmt_pkg::STAT_OK, last: 1'b0};
      pending_nxt   = 1'b0;
    end

    unique case (state_r)
      wsfmt_pkg::ST_IDLE: begin
        if (acc) begin
          if (do_hold) begin
            hram_we        = 1'b1;
            hold_count_nxt = hold_count_r + HCW'(1);
            if (in_data.in_char == wsfmt_pkg::CH_NEWLINE) begin
              if (!nl_r) begin
                first_nxt = hold_count_r;
              end
              lastnl_nxt = hold_count_r;
              nl_nxt     = 1'b1;
            end
          end
          if (do_push) begin
            sram_we   = 1'b1;
            top_nxt   = in_data.push_mode;
            count_nxt = count_r + SCW'(1);
          end
          if (do_pop) begin
            count_nxt = count_r - SCW'(1);
            if (count_r == SCW'(2)) begin
              top_nxt = bottom_r;
            end else begin
              sram_re      = 1'b1;
              top_load_nxt = 1'b1;
            end
          end
          if (do_end) begin
            hold_count_nxt = '0;
            nl_nxt         = 1'b0;
          end
          if (run_drains) begin
            // Snapshot the plan; the hold counters restart for the next run.
            term_nxt    = term;
            a_end_nxt   = plan_a_end;
            b_start_nxt = plan_b_start;
            b_en_nxt    = plan_b_en;
            end_nxt     = hold_count_r;
            synth_nxt   = plan_char;
            rd_idx_nxt  = '0;
            seg_b_nxt   = 1'b0;
            state_nxt   = plan_synth ? wsfmt_pkg::ST_SYNTH : wsfmt_pkg::ST_DRAIN;
          end else if (term_en) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = term;
          end
        end
      end
      wsfmt_pkg::ST_SYNTH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_char: synth_r, char_valid: 1'b1,
                            popped_mode: wsfmt_pkg::MODE_PASS,
                            status: wsfmt_pkg::STAT_OK, last: 1'b0};
          state_nxt     = wsfmt_pkg::ST_FINAL;
        end
      end
      wsfmt_pkg::ST_DRAIN: begin
        // A new read goes out only when the previous byte leaves its slot.
        if (!pending_r || out_free) begin
          if (!seg_b_r) begin
            if (rd_idx_r < a_end_r) begin
              hram_re     = 1'b1;
              pending_nxt = 1'b1;
              rd_idx_nxt  = rd_idx_r + HCW'(1);
            end else if (b_en_r) begin
              rd_idx_nxt = b_start_r;
              seg_b_nxt  = 1'b1;
            end else begin
              state_nxt = wsfmt_pkg::ST_FINAL;
            end
          end else begin
            if (rd_idx_r < end_r) begin
              hram_re     = 1'b1;
              pending_nxt = 1'b1;
              rd_idx_nxt  = rd_idx_r + HCW'(1);
            end else begin
              state_nxt = wsfmt_pkg::ST_FINAL;
            end
          end
        end
      end
      wsfmt_pkg::ST_FINAL: begin
        if (!pending_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = term_r;
          state_nxt     = wsfmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wsfmt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wsfmt_pkg::ST_IDLE;
      pending_r    <= 1'b0;
      top_load_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      count_r      <= SCW'(1);
      hold_count_r <= '0;
      nl_r         <= 1'b0;
      top_r        <= wsfmt_pkg::MODE_PASS;
      bottom_r     <= wsfmt_pkg::MODE_PASS;
    end else begin
      state_r      <= state_nxt;
      pending_r    <= pending_nxt;
      top_load_r   <= top_load_nxt;
      out_valid_r  <= out_valid_nxt;
      count_r      <= count_nxt;
      hold_count_r <= hold_count_nxt;
      nl_r         <= nl_nxt;
      top_r        <= top_nxt;
      bottom_r     <= bottom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    term_r     <= term_nxt;
    first_r    <= first_nxt;
    lastnl_r   <= lastnl_nxt;
    rd_idx_r   <= rd_idx_nxt;
    a_end_r    <= a_end_nxt;
    b_start_r  <= b_start_nxt;
    end_r      <= end_nxt;
    b_en_r     <= b_en_nxt;
    seg_b_r    <= seg_b_nxt;
    synth_r    <= synth_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/wsfmt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data held while the read enable is low. No dependencies.
`default_nettype none

module wsfmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the whitespace run formatter (whitespace_run_formatter).
// Uses wsfmt_pkg for item structs and codes. It predicts every result item in
// step with the input transfers and checks the output stream against that.

module testbench;

  // Whitespace bytes that the package does not name.
  localparam logic [7:0] CH_VTAB  = 8'h0B;
  localparam logic [7:0] CH_FFEED = 8'h0C;

  // Commands other than a pop report this in popped_mode.
  localparam logic [2:0] NO_POP = 3'd0;

  // Cycles to let pass once nothing is expected: a full hold buffer has to
  // be written and read back before the block is truly idle.
  localparam int SETTLE_CYCLES = wsfmt_pkg::HOLD_DEPTH_DEF + 8;

  // Cycles without any transfer before the run is declared hung.
  localparam int IDLE_LIMIT = 2000;

  // Items in each random phase; with the directed items, five phases give
  // about 220 items in all.
  localparam int PHASE_ITEMS = 36;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  wsfmt_pkg::in_item_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  wsfmt_pkg::out_item_t out_data;
  logic                 cfg_we    = 1'b0;
  logic [2:0]           cfg_wdata = wsfmt_pkg::MODE_PASS;

  whitespace_run_formatter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Items waiting to be sent, and the result items predicted for the
  // transfers already made, oldest first.
  wsfmt_pkg::in_item_t  items_to_send[$];
  wsfmt_pkg::out_item_t predicted_out[$];
  int                   mismatches = 0;

  // ---------------------------------------------------------------------
  // Formatter prediction. The state mirrors what the block keeps: the mode
  // stack, its fill level and the whitespace held back for the open run.
  // ---------------------------------------------------------------------
  logic [2:0]           fmt_stack[wsfmt_pkg::STACK_DEPTH_DEF];
  int                   fmt_depth = 1;
  logic [7:0]           held_ws[wsfmt_pkg::HOLD_DEPTH_DEF];
  int                   held_count = 0;
  wsfmt_pkg::out_item_t step_out[$];

  initial fmt_stack[0] = wsfmt_pkg::MODE_PASS;

  function automatic bit is_ws(logic [7:0] c);
    return c == wsfmt_pkg::CH_SPACE || (c >= wsfmt_pkg::CH_TAB && c <= wsfmt_pkg::CH_CR);
  endfunction

  function automatic void emit(logic [7:0] ch, logic valid, logic [2:0] popped,
                               logic [1:0] st);
    wsfmt_pkg::out_item_t r;
    r.out_char    = ch;
    r.char_valid  = valid;
    r.popped_mode = popped;
    r.status      = st;
    r.last        = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void emit_held(int from, int upto);
    for (int i = from; i < upto; i++) emit(held_ws[i], 1'b1, NO_POP, wsfmt_pkg::STAT_OK);
  endfunction

  // Rewrite the held run under the given mode and empty the hold buffer.
  function automatic void close_run(logic [2:0] mode);
    int first_nl;
    int last_nl;
    first_nl = held_count;
    last_nl  = held_count;
    for (int i = 0; i < held_count; i++) begin
      if (held_ws[i] == wsfmt_pkg::CH_NEWLINE) begin
        if (first_nl == held_count) first_nl = i;
        last_nl = i;
      end
    end
    if (held_count > 0) begin
      case (mode)
        wsfmt_pkg::MODE_NONE: begin
        end
        wsfmt_pkg::MODE_SINGLE_SPACE: begin
          emit(wsfmt_pkg::CH_SPACE, 1'b1, NO_POP, wsfmt_pkg::STAT_OK);
        end
        wsfmt_pkg::MODE_SINGLE_NL: begin
          if (first_nl < held_count) emit(wsfmt_pkg::CH_NEWLINE, 1'b1, NO_POP,
                                          wsfmt_pkg::STAT_OK);
          else emit_held(0, held_count);
        end
        wsfmt_pkg::MODE_FIRST_LINE: begin
          emit_held(0, first_nl);
        end
        wsfmt_pkg::MODE_SQUEEZE_NL: begin
          // Blank lines in the middle of the run are squeezed out: keep the
          // first line break and the indentation after the last one.
          if (first_nl == held_count || first_nl == last_nl) begin
            emit_held(0, held_count);
          end else begin
            emit_held(0, first_nl + 1);
            emit_held(last_nl + 1, held_count);
          end
        end
        default: begin
          // Pass, and the two modes that rewrite like pass.
          emit_held(0, held_count);
        end
      endcase
    end
    held_count = 0;
  endfunction

  // Work out the results of one accepted item and queue them for checking.
  function automatic void format_step(wsfmt_pkg::in_item_t it);
    logic [2:0]           top;
    wsfmt_pkg::out_item_t r;
    top = fmt_stack[fmt_depth - 1];
    step_out.delete();
    case (it.kind)
      wsfmt_pkg::KIND_CHAR: begin
        if (top == wsfmt_pkg::MODE_PASS || !is_ws(it.in_char)) begin
          close_run(top);
          emit(it.in_char, 1'b1, NO_POP, wsfmt_pkg::STAT_OK);
        end else if (top != wsfmt_pkg::MODE_NONE) begin
          // Whitespace beyond the buffer is lost and only flagged.
          if (held_count < wsfmt_pkg::HOLD_DEPTH_DEF) begin
            held_ws[held_count] = it.in_char;
            held_count++;
          end else begin
            emit(wsfmt_pkg::CH_NUL, 1'b0, NO_POP, wsfmt_pkg::STAT_OVERFLOW);
          end
        end
      end
      wsfmt_pkg::KIND_PUSH: begin
        close_run(top);
        if (fmt_depth < wsfmt_pkg::STACK_DEPTH_DEF) begin
          fmt_stack[fmt_depth] = it.push_mode;
          fmt_depth++;
          emit(wsfmt_pkg::CH_NUL, 1'b0, NO_POP, wsfmt_pkg::STAT_OK);
        end else begin
          emit(wsfmt_pkg::CH_NUL, 1'b0, NO_POP, wsfmt_pkg::STAT_PUSH_FULL);
        end
      end
      wsfmt_pkg::KIND_POP: begin
        // A refused pop leaves the held run open.
        if (fmt_depth <= 1) begin
          emit(wsfmt_pkg::CH_NUL, 1'b0, wsfmt_pkg::MODE_UNDEFINED, wsfmt_pkg::STAT_POP_LAST);
        end else begin
          close_run(top);
          fmt_depth--;
          emit(wsfmt_pkg::CH_NUL, 1'b0, top, wsfmt_pkg::STAT_OK);
        end
      end
      default: begin
        close_run(top);
        emit(wsfmt_pkg::CH_NUL, 1'b0, NO_POP, wsfmt_pkg::STAT_OK);
      end
    endcase
    for (int i = 0; i < step_out.size(); i++) begin
      r = step_out[i];
      r.last = (i == step_out.size() - 1);
      predicted_out.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver. Items go out in bursts of random length separated by random
  // gaps; a long burst now and then gives stretches at full rate. The
  // prediction runs at the edge where the transfer happens.
  // ---------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) format_step(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (items_to_send.size() > 0) begin
          in_data  <= items_to_send.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6);
            gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20)
                                                      : $urandom_range(0, 3);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor. out_ready follows a rotating 16-bit pattern that is reloaded
  // each time pattern_age wraps: always ready, random, sparse or mostly stalled.
  // Bit 0 is kept set so that no stall lasts beyond one turn of the pattern.
  // ---------------------------------------------------------------------
  logic [15:0] ready_pattern = '1;
  int          pattern_age   = 0;

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    wsfmt_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_out.size() == 0) begin
        $error("result transfer with nothing expected: out_char %0d char_valid %0d",
               out_data.out_char, out_data.char_valid);
        mismatches++;
      end else begin
        want = predicted_out.pop_front();
        check_field("out_char", want.out_char, out_data.out_char);
        check_field("char_valid", want.char_valid, out_data.char_valid);
        check_field("popped_mode", want.popped_mode, out_data.popped_mode);
        check_field("status", want.status, out_data.status);
        check_field("last", want.last, out_data.last);
      end
    end
    out_ready <= ready_pattern[0];
    if (pattern_age == 63) begin
      pattern_age <= 0;
      case ($urandom_range(0, 3))
        0: ready_pattern <= '1;
        1: ready_pattern <= 16'($urandom) | 16'h0001;
        2: ready_pattern <= 16'h0101;
        default: ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
      endcase
    end else begin
      pattern_age   <= pattern_age + 1;
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  // Watchdog: a long stretch with no transfer on either channel means the
  // block has hung.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // Stack depth as the queued items will leave it, so that the generator
  // knows how many pushes fill the stack.
  int queued_depth = 1;

  function automatic void queue_item(logic [1:0] kind, logic [7:0] ch, logic [2:0] mode);
    wsfmt_pkg::in_item_t it;
    it.kind      = kind;
    it.in_char   = ch;
    it.push_mode = mode;
    items_to_send.push_back(it);
    if (kind == wsfmt_pkg::KIND_PUSH && queued_depth < wsfmt_pkg::STACK_DEPTH_DEF)
      queued_depth++;
    else if (kind == wsfmt_pkg::KIND_POP && queued_depth > 1)
      queued_depth--;
  endfunction

  // Newlines are weighted up so that the line-oriented modes see runs with
  // none, one and several of them.
  function automatic logic [7:0] rand_ws();
    case ($urandom_range(0, 7))
      0, 1: return wsfmt_pkg::CH_NEWLINE;
      2: return wsfmt_pkg::CH_TAB;
      3: return CH_VTAB;
      4: return CH_FFEED;
      5: return wsfmt_pkg::CH_CR;
      default: return wsfmt_pkg::CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] rand_text();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_ws(c));
    return c;
  endfunction

  // Mostly text followed by a whitespace run, as in real documents, with
  // mode changes mixed in. Now and then a run too long for the hold buffer,
  // a stack filled past its top or emptied past its bottom, or pure noise.
  task automatic queue_random(int count);
    int made;
    int pick;
    int n;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        n = $urandom_range(1, 4);
        repeat (n) queue_item(wsfmt_pkg::KIND_CHAR, rand_text(), 3'($urandom_range(0, 7)));
        made += n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
        repeat (n) queue_item(wsfmt_pkg::KIND_CHAR, rand_ws(), 3'($urandom_range(0, 7)));
        made += n;
      end else if (pick < 64) begin
        queue_item(wsfmt_pkg::KIND_PUSH, 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)));
        made++;
      end else if (pick < 78) begin
        queue_item(wsfmt_pkg::KIND_POP, 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)));
        made++;
      end else if (pick < 84) begin
        queue_item(wsfmt_pkg::KIND_FLUSH, 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)));
        made++;
      end else if (pick < 89) begin
        n = wsfmt_pkg::STACK_DEPTH_DEF - queued_depth + $urandom_range(1, 2);
        repeat (n) queue_item(wsfmt_pkg::KIND_PUSH, wsfmt_pkg::CH_NUL,
                              3'($urandom_range(0, 7)));
        made += n;
      end else if (pick < 93) begin
        n = queued_depth - 1 + $urandom_range(1, 2);
        repeat (n) queue_item(wsfmt_pkg::KIND_POP, wsfmt_pkg::CH_NUL, wsfmt_pkg::MODE_PASS);
        made += n;
      end else begin
        queue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)));
        made++;
      end
    end
  endtask

  // Wait until every queued item has been sent and every predicted result
  // has arrived, then give a held run time to settle in the hold RAM.
  task automatic wait_quiet();
    do @(negedge clk);
    while (items_to_send.size() != 0 || in_valid || predicted_out.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writing initial_mode also reloads the bottom of the stack at once.
  task automatic write_initial_mode(logic [2:0] mode);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    fmt_stack[0] = mode;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    logic [2:0] base_mode;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    write_initial_mode(wsfmt_pkg::MODE_PASS);

    // Byte extremes, and whitespace going straight out under pass.
    queue_item(wsfmt_pkg::KIND_CHAR, wsfmt_pkg::CH_NUL, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_CHAR, 8'hFF, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_CHAR, CH_VTAB, wsfmt_pkg::MODE_PASS);
    // Under none, whitespace is dropped without being held.
    queue_item(wsfmt_pkg::KIND_PUSH, wsfmt_pkg::CH_NUL, wsfmt_pkg::MODE_NONE);
    queue_item(wsfmt_pkg::KIND_CHAR, wsfmt_pkg::CH_SPACE, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_CHAR, "x", wsfmt_pkg::MODE_PASS);
    // A run with two newlines loses the blank line between them.
    queue_item(wsfmt_pkg::KIND_PUSH, wsfmt_pkg::CH_NUL, wsfmt_pkg::MODE_SQUEEZE_NL);
    queue_item(wsfmt_pkg::KIND_CHAR, wsfmt_pkg::CH_SPACE, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_CHAR, wsfmt_pkg::CH_NEWLINE, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_CHAR, wsfmt_pkg::CH_SPACE, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_CHAR, wsfmt_pkg::CH_NEWLINE, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_CHAR, wsfmt_pkg::CH_TAB, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_CHAR, "y", wsfmt_pkg::MODE_PASS);
    // A flush ends the run, cut at its first newline.
    queue_item(wsfmt_pkg::KIND_PUSH, wsfmt_pkg::CH_NUL, wsfmt_pkg::MODE_FIRST_LINE);
    queue_item(wsfmt_pkg::KIND_CHAR, wsfmt_pkg::CH_SPACE, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_CHAR, wsfmt_pkg::CH_NEWLINE, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_FLUSH, wsfmt_pkg::CH_NUL, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_POP, wsfmt_pkg::CH_NUL, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_POP, wsfmt_pkg::CH_NUL, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_POP, wsfmt_pkg::CH_NUL, wsfmt_pkg::MODE_PASS);
    // A pop ends the run held under the mode it removes.
    queue_item(wsfmt_pkg::KIND_PUSH, wsfmt_pkg::CH_NUL, wsfmt_pkg::MODE_UNDEFINED);
    queue_item(wsfmt_pkg::KIND_CHAR, wsfmt_pkg::CH_SPACE, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_POP, wsfmt_pkg::CH_NUL, wsfmt_pkg::MODE_PASS);
    // Pop with only the bottom mode left, then a flush with nothing held.
    queue_item(wsfmt_pkg::KIND_POP, wsfmt_pkg::CH_NUL, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_FLUSH, wsfmt_pkg::CH_NUL, wsfmt_pkg::MODE_PASS);
    wait_quiet();

    // A run held under one-space mode, then the bottom switched to pass: the
    // next byte writes the held run out whole.
    write_initial_mode(wsfmt_pkg::MODE_SINGLE_SPACE);
    queue_item(wsfmt_pkg::KIND_CHAR, wsfmt_pkg::CH_SPACE, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_CHAR, wsfmt_pkg::CH_TAB, wsfmt_pkg::MODE_PASS);
    wait_quiet();
    write_initial_mode(wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_CHAR, "z", wsfmt_pkg::MODE_PASS);
    wait_quiet();

    // A refused pop keeps the held run open.
    write_initial_mode(wsfmt_pkg::MODE_SINGLE_NL);
    queue_item(wsfmt_pkg::KIND_CHAR, wsfmt_pkg::CH_SPACE, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_POP, wsfmt_pkg::CH_NUL, wsfmt_pkg::MODE_PASS);
    queue_item(wsfmt_pkg::KIND_CHAR, "q", wsfmt_pkg::MODE_PASS);
    wait_quiet();

    // Random phases, each under its own bottom mode, the extremes included.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: base_mode = wsfmt_pkg::MODE_UNDEFINED;
        1: base_mode = wsfmt_pkg::MODE_SINGLE_NL;
        2: base_mode = 3'($urandom_range(0, 7));
        3: base_mode = wsfmt_pkg::MODE_SQUEEZE_NL;
        default: base_mode = wsfmt_pkg::MODE_PASS;
      endcase
      write_initial_mode(base_mode);
      queue_random(PHASE_ITEMS);
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
